[hw/rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Opcodes, status codes and register indexes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CONSOL  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BADPTR  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ALREADY = 3'd4;
  localparam logic [2:0] ST_REJECT  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 8'd1;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
  } result_t;

endpackage

[hw/rtl/ffha_frame_ram.sv]
// ----------------------------------------------------------------------------
// ffha_frame_ram
// Frame table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_frame_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 40,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Allocate, release and consolidate walk the frame list one memory read per
// cycle through the single read port of the frame table.
// One item at a time; the next item is taken while a result waits.
// Reset (rst, synchronous) clears the configuration registers, the used map,
// the ready flag and handshakes.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned MAX_FRAMES   = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [71:0]                     s_axis_tdata,  // opcode, request_size, pointer
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,  // status, address
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import ffha_pkg::*;

  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned LW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned GW = $clog2(2 * MAX_FRAMES + 1);
  localparam int unsigned EW = 33 + LW;
  localparam logic [LW-1:0] NO_LINK = LW'(MAX_FRAMES);
  localparam logic [GW-1:0] G_ALLOC = GW'(MAX_FRAMES - 1);
  localparam logic [GW-1:0] G_CONS  = GW'(2 * MAX_FRAMES - 1);
  localparam logic [33:0] HDR2 = 34'(2 * HEADER_BYTES);
  localparam logic [31:0] HDR  = 32'(HEADER_BYTES);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT2   = 4'd1;
  localparam logic [3:0] S_A_CUR   = 4'd2;
  localparam logic [3:0] S_A_NXT   = 4'd3;
  localparam logic [3:0] S_A_WR    = 4'd4;
  localparam logic [3:0] S_R_CUR   = 4'd5;
  localparam logic [3:0] S_R_NXT   = 4'd6;
  localparam logic [3:0] S_C_FIRST = 4'd7;
  localparam logic [3:0] S_C_NXT   = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]            state;
  logic [31:0]           heap_base;
  logic [31:0]           heap_bytes;
  logic [MAX_FRAMES-1:0] entry_used;
  logic                  heap_ready;
  logic [IW-1:0]         cur;
  logic [31:0]           cur_addr;
  logic                  cur_free;
  logic [LW-1:0]         cur_link;
  logic [GW-1:0]         guard;
  logic [31:0]           req;
  logic [31:0]           target;
  logic [IW-1:0]         slot_r;
  result_t               fin;
  result_t               out_r;
  logic                  out_valid;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [EW-1:0]         wdata;
  logic [IW-1:0]         raddr;
  logic [EW-1:0]         rdata;
  logic [31:0]           rd_addr;
  logic                  rd_free;
  logic [LW-1:0]         rd_link;

  logic [1:0]            in_op;
  logic [31:0]           in_req;
  logic [31:0]           in_ptr;
  logic [32:0]           top;
  logic [32:0]           gap;
  logic [33:0]           need;
  logic                  init_ok;
  logic [IW-1:0]         free_slot;
  logic                  have_slot;

  assign in_op  = s_axis_tdata[1:0];
  assign in_req = s_axis_tdata[33:2];
  assign in_ptr = s_axis_tdata[65:34];
  assign {rd_link, rd_free, rd_addr} = rdata;
  assign top  = {1'b0, heap_base} + {1'b0, heap_bytes};
  assign gap  = {1'b0, rd_addr} - {1'b0, cur_addr};
  assign need = {2'b00, req} + HDR2;
  assign init_ok = (heap_base != 32'd0) && (heap_bytes >= 32'(2 * HEADER_BYTES))
                   && (top <= 33'h1_0000_0000);

  always_comb begin
    free_slot = '0;
    have_slot = 1'b0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (!entry_used[i]) begin
        free_slot = IW'(i);
        have_slot = 1'b1;
      end
    end
  end

  ffha_frame_ram #(.DEPTH(MAX_FRAMES), .WIDTH(EW), .AW(IW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_r.address, out_r.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HEAP_BASE) begin
        heap_base <= cfg_data;
      end else if (cfg_index == REG_HEAP_BYTES) begin
        heap_bytes <= cfg_data;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = {cur_link, cur_free, cur_addr};
    raddr = rd_link[IW-1:0];
    case (state)
      S_IDLE: begin
        raddr = '0;
        if (s_axis_tvalid && in_op == OP_INIT && init_ok) begin
          we    = 1'b1;
          waddr = '0;
          wdata = {LW'(1), 1'b1, heap_base};
        end
      end
      S_INIT2: begin
        we    = 1'b1;
        waddr = IW'(1);
        wdata = {NO_LINK, 1'b0, 32'(top - {1'b0, HDR})};
      end
      S_A_NXT: begin
        raddr = cur_link[IW-1:0];
        we    = ({1'b0, gap} > need) && have_slot;
        waddr = free_slot;
        wdata = {cur_link, 1'b1, cur_addr + HDR + req};
      end
      S_A_WR: begin
        we    = 1'b1;
        wdata = {LW'(slot_r), 1'b0, cur_addr};
      end
      S_R_CUR: begin
        we    = (rd_addr == target) && (rd_link != NO_LINK) && !rd_free;
        wdata = {rd_link, 1'b1, rd_addr};
      end
      S_R_NXT: begin
        we    = rd_free;
        wdata = {rd_link, 1'b1, cur_addr};
      end
      S_C_NXT: begin
        we    = cur_free && rd_free;
        wdata = {rd_link, 1'b1, cur_addr};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      entry_used <= '0;
      heap_ready <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          guard       <= '0;
          cur         <= '0;
          req         <= in_req;
          target      <= in_ptr - HDR;
          fin.address <= 32'd0;
          if (s_axis_tvalid) begin
            case (in_op)
              OP_INIT: begin
                if (init_ok) begin
                  fin.status <= ST_OK;
                  state      <= S_INIT2;
                end else begin
                  fin.status <= ST_REJECT;
                  state      <= S_FIN;
                end
              end
              OP_ALLOC: begin
                if (!heap_ready) begin
                  fin.status <= ST_NOFIT;
                  state      <= S_FIN;
                end else begin
                  fin.status <= ST_OK;
                  state      <= S_A_CUR;
                end
              end
              OP_RELEASE: begin
                if (!heap_ready || in_ptr < HDR) begin
                  fin.status <= ST_BADPTR;
                  state      <= S_FIN;
                end else begin
                  fin.status <= ST_OK;
                  state      <= S_R_CUR;
                end
              end
              default: begin
                fin.status <= ST_OK;
                state      <= heap_ready ? S_C_FIRST : S_FIN;
              end
            endcase
          end
        end
        S_INIT2: begin
          entry_used <= {{(MAX_FRAMES - 2){1'b0}}, 2'b11};
          heap_ready <= 1'b1;
          state      <= S_FIN;
        end
        S_A_CUR: begin
          cur_addr <= rd_addr;
          cur_link <= rd_link;
          guard    <= guard + 1'b1;
          if (rd_link == NO_LINK) begin
            fin.status <= ST_NOFIT;
            state      <= S_FIN;
          end else if (rd_free) begin
            state <= S_A_NXT;
          end else if (guard == G_ALLOC) begin
            fin.status <= ST_NOFIT;
            state      <= S_FIN;
          end else begin
            cur <= rd_link[IW-1:0];
          end
        end
        S_A_NXT: begin
          if ({1'b0, gap} > need) begin
            if (!have_slot) begin
              fin.status <= ST_FULL;
              state      <= S_FIN;
            end else begin
              entry_used[free_slot] <= 1'b1;
              slot_r                <= free_slot;
              state                 <= S_A_WR;
            end
          end else if (guard > G_ALLOC) begin
            fin.status <= ST_NOFIT;
            state      <= S_FIN;
          end else begin
            cur   <= cur_link[IW-1:0];
            state <= S_A_CUR;
          end
        end
        S_A_WR: begin
          fin.address <= cur_addr + HDR;
          state       <= S_FIN;
        end
        S_R_CUR: begin
          cur_addr <= rd_addr;
          cur_link <= rd_link;
          guard    <= guard + 1'b1;
          if (rd_addr == target) begin
            if (rd_link == NO_LINK) begin
              fin.status <= ST_BADPTR;
              state      <= S_FIN;
            end else if (rd_free) begin
              fin.status <= ST_ALREADY;
              state      <= S_FIN;
            end else begin
              state <= S_R_NXT;
            end
          end else if (rd_link == NO_LINK || guard == G_ALLOC) begin
            fin.status <= ST_BADPTR;
            state      <= S_FIN;
          end else begin
            cur <= rd_link[IW-1:0];
          end
        end
        S_R_NXT: begin
          if (rd_free) begin
            entry_used[cur_link[IW-1:0]] <= 1'b0;
          end
          state <= S_FIN;
        end
        S_C_FIRST: begin
          cur_addr <= rd_addr;
          cur_free <= rd_free;
          cur_link <= rd_link;
          state    <= (rd_link == NO_LINK) ? S_FIN : S_C_NXT;
        end
        S_C_NXT: begin
          guard    <= guard + 1'b1;
          cur_link <= rd_link;
          if (cur_free && rd_free) begin
            entry_used[cur_link[IW-1:0]] <= 1'b0;
          end else begin
            cur      <= cur_link[IW-1:0];
            cur_addr <= rd_addr;
            cur_free <= rd_free;
          end
          if (rd_link == NO_LINK || guard == G_CONS) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || m_axis_tready) begin
            out_r <= fin;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_head_kept: assert property (@(posedge clk) disable iff (rst)
    heap_ready |-> (entry_used[0] && entry_used[1]))
    else $error("head or end frame entry released");

  a_unready_empty: assert property (@(posedge clk) disable iff (rst)
    !heap_ready |-> (entry_used == '0))
    else $error("entries used before init");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_r.status <= ST_REJECT))
    else $error("status code out of range");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_r.status != ST_OK) |-> (out_r.address == 32'd0))
    else $error("address on failed item");

endmodule

[verif/first_fit_heap_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives init, allocate, release and consolidate commands into the heap
// allocator and compares every status and address against an internal
// first-fit frame list model, under random source and sink stalls.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned FRAMES = 64;
  localparam int unsigned HDR    = 8;
  localparam int unsigned NONE   = FRAMES;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  first_fit_heap_allocator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("first_fit_heap_allocator_tb failed");
    $finish;
  end

  typedef struct {
    logic [1:0]  op;
    logic [31:0] size;
    logic [31:0] ptr;
    bit          typed;
    logic [2:0]  status;
    logic [31:0] addr;
  } cmd_row_t;

  logic [31:0] base_reg, bytes_reg;
  logic [31:0] fr_addr [FRAMES];
  bit          fr_free [FRAMES];
  int unsigned fr_link [FRAMES];
  bit          fr_used [FRAMES];
  bit          ready_q;

  result_t     pending_results[$];
  logic [31:0] live_ptrs[$];
  int          errors = 0;
  int          src_idle = 14, snk_idle = 58;
  bit          sink_hold = 1'b0;

  function automatic void join_next(int unsigned c);
    int unsigned n;
    n = fr_link[c];
    fr_link[c] = fr_link[n];
    fr_used[n] = 1'b0;
  endfunction

  function automatic result_t heap_predict(logic [1:0] op, logic [31:0] sz, logic [31:0] p);
    result_t r;
    logic [63:0] gap, tgt;
    int unsigned c, n, g, s;
    r.status = ST_OK;
    r.address = '0;
    case (op)
      OP_INIT: begin
        if (base_reg == 0 || bytes_reg < 2 * HDR ||
            64'(base_reg) + 64'(bytes_reg) > 64'h1_0000_0000) begin
          r.status = ST_REJECT;
        end else begin
          foreach (fr_used[i]) fr_used[i] = 1'b0;
          fr_used[0] = 1'b1; fr_addr[0] = base_reg; fr_free[0] = 1'b1; fr_link[0] = 1;
          fr_used[1] = 1'b1; fr_addr[1] = 32'(64'(base_reg) + bytes_reg - HDR);
          fr_free[1] = 1'b0; fr_link[1] = NONE;
          ready_q = 1'b1;
        end
      end
      OP_ALLOC: begin
        r.status = ST_NOFIT;
        c = 0;
        if (ready_q) begin
          for (g = 0; g < FRAMES && c < NONE; g++) begin
            n = fr_link[c];
            if (!fr_free[c]) begin
              c = n;
              continue;
            end
            if (n >= NONE) break;
            gap = 64'(fr_addr[n]) - 64'(fr_addr[c]);
            if (gap > 64'(sz) + 2 * HDR) begin
              for (s = 0; s < FRAMES; s++) if (!fr_used[s]) break;
              if (s >= FRAMES) begin
                r.status = ST_FULL;
              end else begin
                fr_used[s] = 1'b1; fr_addr[s] = 32'(64'(fr_addr[c]) + HDR + sz);
                fr_free[s] = 1'b1; fr_link[s] = n;
                fr_link[c] = s; fr_free[c] = 1'b0;
                r.status = ST_OK;
                r.address = fr_addr[c] + HDR;
              end
              break;
            end
            c = n;
          end
        end
      end
      OP_RELEASE: begin
        if (!ready_q || p < HDR) begin
          r.status = ST_BADPTR;
        end else begin
          tgt = p - HDR;
          c = 0;
          for (g = 0; g < FRAMES && c < NONE; g++) begin
            if (fr_addr[c] == tgt) break;
            c = fr_link[c];
          end
          if (g >= FRAMES || c >= NONE || fr_link[c] >= NONE) r.status = ST_BADPTR;
          else if (fr_free[c]) r.status = ST_ALREADY;
          else begin
            fr_free[c] = 1'b1;
            if (fr_free[fr_link[c]]) join_next(c);
          end
        end
      end
      default: begin
        c = 0;
        if (ready_q) begin
          for (g = 0; g < 2 * FRAMES && c < NONE; g++) begin
            n = fr_link[c];
            if (n >= NONE) break;
            if (fr_free[c] && fr_free[n]) join_next(c);
            else c = n;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HEAP_BASE) base_reg = val;
    else bytes_reg = val;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (pending_results.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic send_cmd(logic [1:0] op, logic [31:0] sz, logic [31:0] p);
    while ($urandom_range(99) < src_idle) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, p, sz, op};
    do @(posedge clk); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    pending_results.push_back(heap_predict(op, sz, p));
    @(posedge clk);
  endtask

  task automatic rand_cmd();
    int k;
    logic [31:0] p, sz;
    k = $urandom_range(99);
    sz = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
    if (k < 45) send_cmd(OP_ALLOC, sz, '0);
    else if (k < 80 && live_ptrs.size() != 0) begin
      p = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
      send_cmd(OP_RELEASE, '0, p);
    end else if (k < 88) send_cmd(OP_RELEASE, '0, $urandom);
    else if (k < 96) send_cmd(OP_CONSOL, $urandom, $urandom);
    else send_cmd(OP_INIT, $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[34:0];
        if (pending_results.size() == 0) begin
          $error("unexpected result status %0d address %h", got.status, got.address);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.address !== want.address) begin
            $error("address expected %h actual %h", want.address, got.address);
            errors++;
          end
          if (got.status == ST_OK && got.address != 0) live_ptrs.push_back(got.address);
        end
      end
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_idle);
    end
  end

  cmd_row_t rows[$];

  initial begin
    base_reg = 0; bytes_reg = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{OP_ALLOC,   32'd16, 32'd0, 1, ST_NOFIT, 32'd0});
    rows.push_back('{OP_RELEASE, 32'd0, 32'h100, 1, ST_BADPTR, 32'd0});
    rows.push_back('{OP_CONSOL,  32'd0, 32'd0, 1, ST_OK, 32'd0});
    rows.push_back('{OP_INIT,    32'd0, 32'd0, 1, ST_REJECT, 32'd0});
    foreach (rows[i]) begin
      send_cmd(rows[i].op, rows[i].size, rows[i].ptr);
      pending_results[$].status = rows[i].status;
      pending_results[$].address = rows[i].addr;
    end
    drain();

    write_reg(REG_HEAP_BASE, 32'h0000_1000);
    write_reg(REG_HEAP_BYTES, 32'd15);
    send_cmd(OP_INIT, '0, '0);
    drain();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(REG_HEAP_BYTES, 32'h0000_0200);
    send_cmd(OP_INIT, '0, '0);
    drain();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(REG_HEAP_BYTES, 32'h0000_0100);
    rows.delete();
    rows.push_back('{OP_INIT,    32'd0, 32'd0, 1, ST_OK, 32'd0});
    rows.push_back('{OP_ALLOC,   32'hFFFF_FFFF, 32'd0, 1, ST_NOFIT, 32'd0});
    rows.push_back('{OP_ALLOC,   32'd0, 32'd0, 1, ST_OK, 32'hFFFF_FF08});
    rows.push_back('{OP_ALLOC,   32'd200, 32'd0, 0, ST_OK, 32'd0});
    rows.push_back('{OP_ALLOC,   32'd200, 32'd0, 0, ST_OK, 32'd0});
    rows.push_back('{OP_RELEASE, 32'd0, 32'd7, 1, ST_BADPTR, 32'd0});
    rows.push_back('{OP_RELEASE, 32'd0, 32'hFFFF_FFF8, 1, ST_BADPTR, 32'd0});
    rows.push_back('{OP_RELEASE, 32'd0, 32'hFFFF_FF08, 1, ST_OK, 32'd0});
    rows.push_back('{OP_RELEASE, 32'd0, 32'hFFFF_FF08, 1, ST_ALREADY, 32'd0});
    rows.push_back('{OP_RELEASE, 32'd0, 32'hFFFF_FF10, 0, ST_OK, 32'd0});
    rows.push_back('{OP_CONSOL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, ST_OK, 32'd0});
    rows.push_back('{OP_ALLOC,   32'd0, 32'd0, 0, ST_OK, 32'd0});
    foreach (rows[i]) begin
      send_cmd(rows[i].op, rows[i].size, rows[i].ptr);
      if (rows[i].typed && pending_results[$].status !== rows[i].status) begin
        $error("status expected %0d actual %0d", rows[i].status, pending_results[$].status);
        errors++;
      end
    end
    drain();

    // fill the frame table until it reports full
    write_reg(REG_HEAP_BASE, 32'h0001_0000);
    write_reg(REG_HEAP_BYTES, 32'h0001_0000);
    send_cmd(OP_INIT, '0, '0);
    for (int i = 0; i < 66; i++) send_cmd(OP_ALLOC, 32'd4, '0);
    drain();
    live_ptrs.delete();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin src_idle = 58; snk_idle = 14; end
      if (ph == 2) begin src_idle = 0; snk_idle = 0; end
      write_reg(REG_HEAP_BASE, 32'h0000_0010 << ($urandom_range(3) * 8));
      write_reg(REG_HEAP_BYTES, 32'd512 << $urandom_range(4));
      live_ptrs.delete();
      send_cmd(OP_INIT, '0, '0);
      if (ph == 1) begin
        sink_hold = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            sink_hold = 1'b0;
          end
          for (int i = 0; i < 20; i++) rand_cmd();
        join
      end
      for (int i = 0; i < 230; i++) begin
        rand_cmd();
        if (i == 100) drain();
      end
      drain();
    end

    if (pending_results.size() != 0) begin
      $error("results missing expected %0d actual 0", pending_results.size());
      errors++;
    end
    if (errors == 0) $display("first_fit_heap_allocator_tb passed");
    else $display("first_fit_heap_allocator_tb failed");
    $finish;
  end
endmodule

[first_fit_heap_allocator.f]
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_frame_ram.sv
hw/rtl/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_tb.sv
